// ===== sv/rpn_pkg.sv =====
`default_nettype none

package rpn_pkg;

    localparam int DATA_W              = 32;
    localparam int CMD_W               = 3;
    localparam int COUNT_W             = 5;
    localparam int STATUS_W            = 2;
    localparam int STACK_DEPTH_DEFAULT = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_SUB    = 3'd2,
        CMD_MUL    = 3'd3,
        CMD_DIV    = 3'd4,
        CMD_FINISH = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_DIVZERO = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPER,
        S_DIV,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [COUNT_W-1:0]       stack_count;
        status_t                  status;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/rpn_in_if.sv =====
`default_nettype none

interface rpn_in_if;
    logic                             valid;
    logic                             ready;
    logic [rpn_pkg::CMD_W-1:0]        command;
    logic signed [rpn_pkg::DATA_W-1:0] number;

    modport source (output valid, output command, output number, input ready);
    modport sink (input valid, input command, input number, output ready);
endinterface

`default_nettype wire

// ===== sv/rpn_out_if.sv =====
`default_nettype none

interface rpn_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [rpn_pkg::DATA_W-1:0] top_value;
    logic [rpn_pkg::COUNT_W-1:0]       stack_count;
    logic [rpn_pkg::STATUS_W-1:0]      status;

    modport source (output valid, output top_value, output stack_count, output status,
                    input ready);
    modport sink (input valid, input top_value, input stack_count, input status,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/rpn_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module rpn_ram #(
    parameter int WIDTH = rpn_pkg::DATA_W,
    parameter int DEPTH = rpn_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/rpn_div.sv =====
`default_nettype none

// Signed divider truncating toward zero; restoring, one quotient bit per cycle.
module rpn_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [rpn_pkg::DATA_W-1:0] dividend,
    input  wire logic signed [rpn_pkg::DATA_W-1:0] divisor,
    output logic signed [rpn_pkg::DATA_W-1:0]      quotient,
    output logic                                   done
);

    localparam int W  = rpn_pkg::DATA_W;
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  den_reg, den_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[W-1]};
        diff      = trial - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            quo_next  = dividend[W-1] ? (W'(0) - W'(dividend)) : W'(dividend);
            den_next  = divisor[W-1] ? (W'(0) - W'(divisor)) : W'(divisor);
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== sv/rpn_stack_evaluator.sv =====
`default_nettype none

// Reverse Polish evaluator on an operand stack held in a synchronous RAM.
// The in_ch channel carries one token per item: a command (push, add, subtract,
// multiply, divide, finish) and a signed 32-bit number used only by push.
// The out_ch channel returns one item per token: the top of the stack after
// the token (or the final result on finish), the entry count and a status.
// The top of stack is cached in a register and every entry is also kept in
// the RAM, so an operator needs just one RAM read for the entry below the top.
// Push, finish, unused codes, a full stack and a missing operand send their
// result straight to the output stage; add, subtract, multiply and divide by
// zero first wait for the registered RAM read, and divide then also waits for
// the divider, which resolves one quotient bit per cycle.
// A new item is accepted only while no operator is in flight, so pushes and
// finishes go at one item per cycle while the output does not stall, and an
// operator's result is delivered before the next item is accepted.
// Results go to an output register with a one-entry holding stage behind it,
// so one further item is accepted while a result waits; when the receiver
// keeps stalling, in_ch.ready drops until the held result moves out.
// Reset empties the stack and the output; the RAM contents are not cleared,
// since only entries below the stack pointer are ever read.
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rpn_in_if.sink     in_ch,
    rpn_out_if.source  out_ch
);

    localparam int W   = rpn_pkg::DATA_W;
    localparam int CW  = rpn_pkg::COUNT_W;
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    rpn_pkg::state_t  state_reg, state_next;
    logic [SPW-1:0]   sp_reg, sp_next;
    logic signed [W-1:0] top_reg, top_next;
    rpn_pkg::cmd_t    cmd_reg, cmd_next;
    logic             out_valid_reg, out_valid_next;
    rpn_pkg::result_t out_res_reg, out_res_next;
    rpn_pkg::result_t pend_res_reg, pend_res_next;

    rpn_pkg::cmd_t    cmd_c;
    rpn_pkg::result_t res_c;
    logic             deliver_c;
    logic             commit_c;
    logic signed [W-1:0] commit_val_c;
    logic             slot_free_c;
    logic signed [W-1:0] cur_top_c;
    logic [SPW-1:0]   sp_minus2_c;
    logic signed [W-1:0] op_a_c;

    logic             ram_we_c;
    logic [AW-1:0]    ram_waddr_c;
    logic [W-1:0]     ram_wdata_c;
    logic [W-1:0]     ram_rdata;

    logic             div_start_c;
    logic signed [W-1:0] div_quotient;
    logic             div_done;

    rpn_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we_c),
        .waddr (ram_waddr_c),
        .wdata (ram_wdata_c),
        .raddr (sp_minus2_c[AW-1:0]),
        .rdata (ram_rdata)
    );

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_c),
        .dividend (op_a_c),
        .divisor  (top_reg),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign sp_minus2_c = sp_reg - SPW'(2);
    assign cur_top_c   = (sp_reg == '0) ? '0 : top_reg;
    assign slot_free_c = !out_valid_reg || out_ch.ready;
    assign op_a_c      = ram_rdata;
    assign cmd_c       = rpn_pkg::cmd_t'(in_ch.command);

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        top_next       = top_reg;
        cmd_next       = cmd_reg;
        pend_res_next  = pend_res_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        in_ch.ready    = 1'b0;
        deliver_c      = 1'b0;
        commit_c       = 1'b0;
        commit_val_c   = '0;
        div_start_c    = 1'b0;
        ram_we_c       = 1'b0;
        ram_waddr_c    = sp_reg[AW-1:0];
        ram_wdata_c    = in_ch.number;
        res_c          = '{top_value: cur_top_c, stack_count: CW'(sp_reg),
                           status: rpn_pkg::ST_OK};

        case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    case (cmd_c)
                        rpn_pkg::CMD_PUSH:
                        begin
                            deliver_c = 1'b1;
                            if (sp_reg == SPW'(STACK_DEPTH))
                            begin
                                res_c.status = rpn_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we_c          = 1'b1;
                                top_next          = in_ch.number;
                                sp_next           = sp_reg + SPW'(1);
                                res_c.top_value   = in_ch.number;
                                res_c.stack_count = CW'(sp_reg + SPW'(1));
                            end
                        end
                        rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
                        rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV:
                        begin
                            if (sp_reg < SPW'(2))
                            begin
                                deliver_c    = 1'b1;
                                res_c.status = rpn_pkg::ST_MISSING;
                            end
                            else
                            begin
                                // The RAM read of the entry below the top starts now.
                                cmd_next   = cmd_c;
                                state_next = rpn_pkg::S_OPER;
                            end
                        end
                        rpn_pkg::CMD_FINISH:
                        begin
                            deliver_c         = 1'b1;
                            res_c.stack_count = '0;
                            if (sp_reg == '0)
                            begin
                                res_c.status = rpn_pkg::ST_MISSING;
                            end
                            sp_next = '0;
                        end
                        default:
                        begin
                            // Unused command codes report the stack untouched.
                            deliver_c = 1'b1;
                        end
                    endcase
                end
            end
            rpn_pkg::S_OPER:
            begin
                case (cmd_reg)
                    rpn_pkg::CMD_ADD:
                    begin
                        commit_c     = 1'b1;
                        commit_val_c = op_a_c + top_reg;
                    end
                    rpn_pkg::CMD_SUB:
                    begin
                        commit_c     = 1'b1;
                        commit_val_c = op_a_c - top_reg;
                    end
                    rpn_pkg::CMD_MUL:
                    begin
                        commit_c     = 1'b1;
                        commit_val_c = op_a_c * top_reg;
                    end
                    default:
                    begin
                        if (top_reg == '0)
                        begin
                            deliver_c    = 1'b1;
                            res_c.status = rpn_pkg::ST_DIVZERO;
                        end
                        else
                        begin
                            div_start_c = 1'b1;
                            state_next  = rpn_pkg::S_DIV;
                        end
                    end
                endcase
            end
            rpn_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    commit_c     = 1'b1;
                    commit_val_c = div_quotient;
                end
            end
            rpn_pkg::S_HOLD:
            begin
                if (slot_free_c)
                begin
                    out_res_next   = pend_res_reg;
                    out_valid_next = 1'b1;
                    state_next     = rpn_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rpn_pkg::S_IDLE;
            end
        endcase

        // An operator result replaces the two top entries with one.
        if (commit_c)
        begin
            deliver_c         = 1'b1;
            ram_we_c          = 1'b1;
            ram_waddr_c       = sp_minus2_c[AW-1:0];
            ram_wdata_c       = commit_val_c;
            top_next          = commit_val_c;
            sp_next           = sp_reg - SPW'(1);
            res_c.top_value   = commit_val_c;
            res_c.stack_count = CW'(sp_reg - SPW'(1));
        end

        if (deliver_c)
        begin
            if (slot_free_c)
            begin
                out_res_next   = res_c;
                out_valid_next = 1'b1;
                state_next     = rpn_pkg::S_IDLE;
            end
            else
            begin
                pend_res_next = res_c;
                state_next    = rpn_pkg::S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpn_pkg::S_IDLE;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        cmd_reg      <= cmd_next;
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.top_value   = out_res_reg.top_value;
    assign out_ch.stack_count = out_res_reg.stack_count;
    assign out_ch.status      = out_res_reg.status;

    // The stack pointer never passes the stack depth.
    a_sp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    // A push on a stack that is not full adds exactly one entry.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.command == rpn_pkg::CMD_PUSH
         && sp_reg < SPW'(STACK_DEPTH))
        |=> sp_reg == $past(sp_reg) + SPW'(1))
        else $error("push did not grow the stack by one");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == rpn_pkg::S_DIV)
        else $error("divider finished outside the divide state");

    // A result is held back only while the output register is occupied.
    a_hold_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rpn_pkg::S_HOLD |-> out_valid_reg)
        else $error("holding a result with an empty output register");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
module tb;
    import rpn_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEFAULT;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 400000;
    // Hold-off of the result side in the pressure test. It is long enough
    // to fill the output stages and keep the input stalled for many cycles.
    localparam int HOLD_CYCLES = 120;
    // Drain time after the last result: longer than the divide latency.
    localparam int DRAIN_CYCLES = 60;

    // Command codes without a name in the package. The block treats them as no-ops.
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic clk;
    logic rst_n;

    rpn_in_if  in_ch ();
    rpn_out_if out_ch ();

    rpn_stack_evaluator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow copy of the operand stack. The sender updates it in the same
    // step as each accepted item, so the stimulus can read the depth right
    // after a send returns.
    logic signed [DATA_W-1:0] shadow_stack [DEPTH];
    int                       shadow_depth;

    // Results owed by the block, oldest first.
    result_t outcome_q [$];

    int error_count;
    int cycle_count;

    // Sender idling. A burst of items is sent back to back, then a gap
    // follows. A maximum gap of zero means the sender never idles.
    int tx_max_gap;
    int tx_max_burst;
    int burst_left;

    // Receiver stall control.
    rx_mode_t   rx_mode;
    int         rx_pct;
    logic [7:0] rx_pattern;
    int         rx_hold_req;

    // The clock runs at a period of 20 time units.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog. A run that hangs, such as a stuck ready or a lost result,
    // ends here with the failure message.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles, %0d results still due",
                     cycle_count, outcome_q.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    // Computes what one token does to the shadow stack, and the result
    // item that the block must return for it.
    function automatic result_t eval_token(input logic [CMD_W-1:0] cmd,
                                           input logic signed [DATA_W-1:0] num);
        result_t                  res;
        logic signed [DATA_W-1:0] lhs;
        logic signed [DATA_W-1:0] rhs;
        logic signed [DATA_W-1:0] val;
        logic [DATA_W-1:0]        mag_l;
        logic [DATA_W-1:0]        mag_r;
        logic [DATA_W-1:0]        quo;
        res.status    = ST_OK;
        res.top_value = '0;
        val           = '0;
        case (cmd)
            CMD_PUSH:
            begin
                if (shadow_depth >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    shadow_stack[IDX_W'(shadow_depth)] = num;
                    shadow_depth++;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
            begin
                if (shadow_depth < 2)
                    res.status = ST_MISSING;
                else
                begin
                    rhs = shadow_stack[IDX_W'(shadow_depth - 1)];
                    lhs = shadow_stack[IDX_W'(shadow_depth - 2)];
                    case (cmd)
                        CMD_ADD: val = lhs + rhs;
                        CMD_SUB: val = lhs - rhs;
                        CMD_MUL: val = lhs * rhs;
                        default:
                        begin
                            if (rhs == 0)
                                res.status = ST_DIVZERO;
                            else
                            begin
                                // Divide the magnitudes and then restore the sign. The
                                // quotient is truncated toward zero, and the most
                                // negative value divided by minus one wraps to itself.
                                mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                                mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                                quo   = mag_l / mag_r;
                                val   = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
                            end
                        end
                    endcase
                    if (res.status == ST_OK)
                    begin
                        shadow_stack[IDX_W'(shadow_depth - 2)] = val;
                        shadow_depth--;
                    end
                end
            end
            CMD_FINISH:
            begin
                if (shadow_depth == 0)
                    res.status = ST_MISSING;
                else
                begin
                    res.top_value = shadow_stack[IDX_W'(shadow_depth - 1)];
                    shadow_depth  = 0;
                end
            end
            default:
                ;
        endcase
        if (cmd != CMD_FINISH && shadow_depth != 0)
            res.top_value = shadow_stack[IDX_W'(shadow_depth - 1)];
        res.stack_count = shadow_depth[COUNT_W-1:0];
        return res;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        error_count++;
        $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Sends one token. The valid signal stays high from one item to the
    // next inside a burst. Between bursts the sender idles for a random
    // gap. The token counts as accepted at the first rising edge that has
    // ready high, and its expected result is queued in that same step.
    task automatic send_token(input logic [CMD_W-1:0] cmd,
                              input logic signed [DATA_W-1:0] num);
        int gap;
        if (burst_left <= 0)
        begin
            gap        = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
            burst_left = $urandom_range(1, tx_max_burst);
            repeat (gap)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.number  <= num;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        outcome_q.insert(outcome_q.size(), eval_token(cmd, num));
    endtask

    // Operand values lean on the corners: the most negative and most
    // positive values, zero, plus and minus one, and small numbers. Small
    // numbers make exact quotients and zero divisors common. The rest are
    // full 32-bit random values, so every bit takes both values.
    function automatic logic signed [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return '0;
            3:       return -1;
            4:       return 1;
            5, 6:    return $signed($urandom_range(0, 200)) - 100;
            default: return $signed($urandom);
        endcase
    endfunction

    // Picks an arithmetic operator. Divides are kept rarer than the others
    // because each one holds the input for the full divider latency.
    function automatic logic [CMD_W-1:0] pick_operator();
        if ($urandom_range(0, 99) < 15)
            return CMD_DIV;
        return CMD_W'($urandom_range(CMD_ADD, CMD_MUL));
    endfunction

    task automatic set_traffic(input rx_mode_t mode, input int pct,
                               input int max_gap, input int max_burst);
        rx_mode      = mode;
        rx_pct       = pct;
        rx_pattern   = 8'($urandom_range(1, 255));
        tx_max_gap   = max_gap;
        tx_max_burst = max_burst;
        burst_left   = 0;
    endtask

    // Receiver. Ready changes only at falling edges. A hold-off request
    // from the pressure test takes priority and is counted down here,
    // one cycle at a time.
    initial
    begin : receiver
        int hold_left;
        int phase;
        hold_left    = 0;
        phase        = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:  out_ch.ready <= 1'b1;
                    RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 99) < rx_pct);
                    default:    out_ch.ready <= rx_pattern[phase[2:0]];
                endcase
            end
            phase = (phase + 1) % 8;
        end
    end

    // Result checker. Each accepted result is compared with the oldest
    // expected one, field by field. Four-state compares catch X and Z.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (outcome_q.size() == 0)
                report_mismatch($sformatf("result with none due: top %0d count %0d status %0d",
                                          out_ch.top_value, out_ch.stack_count,
                                          out_ch.status));
            else
            begin
                want = outcome_q.pop_front();
                if (out_ch.top_value !== want.top_value ||
                    out_ch.stack_count !== want.stack_count ||
                    out_ch.status !== want.status)
                    report_mismatch($sformatf(
                        "top %0d want %0d, count %0d want %0d, status %0d want %0d",
                        out_ch.top_value, want.top_value, out_ch.stack_count,
                        want.stack_count, out_ch.status, want.status));
            end
        end
    end

    // Directed tokens: the missing-operand and divide-by-zero statuses, the wrap cases of every
    // operator, truncation of negative quotients, the spare codes, and a
    // finish both on an empty stack and on a stack of several entries.
    task automatic test_directed();
        send_token(CMD_FINISH, 0);        // finish on an empty stack
        send_token(CMD_ADD, 0);           // operator on an empty stack
        send_token(CMD_PUSH, 7);
        send_token(CMD_SUB, 0);           // operator with only one entry
        send_token(CMD_SPARE_6, -1);      // spare code reports the top
        send_token(CMD_PUSH, MOST_NEG);
        send_token(CMD_PUSH, -1);
        send_token(CMD_DIV, 0);           // most negative over minus one wraps
        send_token(CMD_PUSH, 0);
        send_token(CMD_DIV, 0);           // divide by zero leaves the stack as it was
        send_token(CMD_SPARE_7, MOST_POS);
        send_token(CMD_FINISH, 0);        // three entries, the top one is returned
        send_token(CMD_PUSH, MOST_POS);
        send_token(CMD_PUSH, 1);
        send_token(CMD_ADD, 0);           // positive overflow wraps
        send_token(CMD_PUSH, 1);
        send_token(CMD_SUB, 0);           // negative overflow wraps
        send_token(CMD_PUSH, 2);
        send_token(CMD_MUL, 0);           // the product keeps its low 32 bits
        send_token(CMD_PUSH, -7);
        send_token(CMD_PUSH, 2);
        send_token(CMD_DIV, 0);           // a negative dividend truncates toward zero
        send_token(CMD_PUSH, 7);
        send_token(CMD_PUSH, -2);
        send_token(CMD_DIV, 0);           // a negative divisor truncates toward zero
        send_token(CMD_FINISH, 0);
    endtask

    // Twice fills the stack to its limit with random operands, pushes past the
    // limit, and then works one to six random operators on the full stack and
    // pushes once more before it is finished.
    task automatic test_stack_full();
        repeat (2)
        begin
            while (shadow_depth < DEPTH)
                send_token(CMD_PUSH, pick_operand());
            repeat (3)
                send_token(CMD_PUSH, pick_operand());
            repeat ($urandom_range(1, 6))
                send_token(pick_operator(), pick_operand());
            send_token(CMD_PUSH, pick_operand());
            send_token(CMD_FINISH, 0);
        end
    endtask

    // Random well-formed expressions: pushes and operators chosen so that
    // the operands are mostly there, closed now and then by a finish. A
    // share of the tokens is noise: any code, with any number.
    task automatic test_random_expressions(input int count, input int noise_pct,
                                           input int push_pct);
        int roll;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < noise_pct)
                send_token(CMD_W'($urandom_range(0, 7)), $signed($urandom));
            else if (shadow_depth == 1 && roll < 20)
                send_token(CMD_FINISH, $signed($urandom));
            else if (shadow_depth < 2)
                send_token(CMD_PUSH, pick_operand());
            else if (shadow_depth >= DEPTH)
                send_token(pick_operator(), $signed($urandom));
            else if (roll < push_pct)
                send_token(CMD_PUSH, pick_operand());
            else if (roll < 94)
                send_token(pick_operator(), $signed($urandom));
            else
                send_token(CMD_FINISH, $signed($urandom));
        end
    endtask

    // The receiver holds off for a long stretch while the sender offers
    // tokens without a gap. The result stages fill, the input stalls, and
    // the flow has to resume without a lost or doubled item.
    task automatic test_backpressure();
        set_traffic(RX_ALWAYS, 100, 0, 1);
        rx_hold_req = HOLD_CYCLES;
        test_random_expressions(40, 0, 50);
    endtask

    initial
    begin : main
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_PUSH;
        in_ch.number  = '0;
        shadow_depth  = 0;
        error_count   = 0;
        cycle_count   = 0;
        rx_hold_req   = 0;
        set_traffic(RX_RANDOM, 70, 3, 6);

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();

        set_traffic(RX_PATTERN, 0, 2, 10);
        test_stack_full();

        set_traffic(RX_RANDOM, 60, 4, 8);
        test_random_expressions(600, 10, 45);

        test_backpressure();

        set_traffic(RX_PATTERN, 0, 5, 4);
        test_random_expressions(600, 15, 60);

        // No idling on either side: tokens back to back, results taken at once.
        set_traffic(RX_ALWAYS, 100, 0, 1);
        test_random_expressions(600, 5, 50);

        @(negedge clk);
        in_ch.valid <= 1'b0;

        // Let the receiver drain everything, then watch a little longer for
        // stray results. The watchdog covers a result that never comes.
        set_traffic(RX_RANDOM, 50, 0, 1);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
